/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the frame builder RTL.
// No dependencies; include inside a module body after the package import.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfb assertion failed");

`endif

/* hw/rtl/cfb_pkg.sv */
// Package for the checksummed frame builder: command type, constants, checksum helper.
// No dependencies.
`default_nettype none

package cfb_pkg;

  localparam int unsigned MAX_PAYLOAD = 1024;
  localparam int unsigned LEN_W       = 11;
  localparam int unsigned SEQ_W       = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SUM_W       = 16;

  // Command queue between front and back
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // Input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  // Header flag byte values
  localparam logic [BYTE_W-1:0] FLAG_LAST = 8'h00;
  localparam logic [BYTE_W-1:0] FLAG_MORE = 8'h01;

  // Header step counter: steps 1..8 follow the flag byte
  localparam int unsigned STEP_W    = 4;
  localparam logic [STEP_W-1:0] STEP_FIRST = 4'd1;
  localparam logic [STEP_W-1:0] STEP_LAST  = 4'd8;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               last;   // data byte closes the frame
    logic               eod;
    logic [SEQ_W-1:0]   seq;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  data;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_HDR  = 2'd1,
    BK_CHK  = 2'd2
  } bk_state_t;

  // 16-bit ones-complement add with end-around carry
  function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] s,
                                               input logic [BYTE_W-1:0] b);
    logic [SUM_W:0] t;
    t = {1'b0, s} + {{(SUM_W + 1 - BYTE_W){1'b0}}, b};
    if (t[SUM_W]) begin
      sum_add = t[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, 1'b1};
    end else begin
      sum_add = t[SUM_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/checksummed_frame_builder_core.sv */
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_push / in_full   | action, seq_num, payload_length,
//         |           |                     | end_of_data, payload_byte
// out_    | output    | out_pop / out_empty | frame_byte, frame_end
//
// A data item reaches the output register at the edge that takes it from the command queue;
// a closing data item is followed by the checksum byte from the checksum state.
// A start item puts nine bytes through the serializer (ten with an empty payload), one
// byte per cycle while the single output register is empty or being popped. The four-entry
// command queue absorbs header bursts; in_full is high only while it is full. Synchronous
// active-low reset clears frame state, queue and output.
// Top level of the checksummed frame builder.
// Depends on cfb_pkg, cfb_front, cfb_cmd_fifo, cfb_back.
`default_nettype none

module checksummed_frame_builder_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic                       in_action,
  input  wire logic [cfb_pkg::SEQ_W-1:0]  in_seq_num,
  input  wire logic [cfb_pkg::LEN_W-1:0]  in_payload_length,
  input  wire logic                       in_end_of_data,
  input  wire logic [cfb_pkg::BYTE_W-1:0] in_payload_byte,
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output logic [cfb_pkg::BYTE_W-1:0]      out_frame_byte,
  output logic                            out_frame_end
);
  import cfb_pkg::*;

  logic in_accept;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_full;
  logic cmd_empty;
  logic cmd_pop;

  assign in_full   = cmd_full;
  assign in_accept = in_push && !cmd_full;

  cfb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_accept),
    .action         (in_action),
    .seq_num        (in_seq_num),
    .payload_length (in_payload_length),
    .end_of_data    (in_end_of_data),
    .payload_byte   (in_payload_byte),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in)
  );

  cfb_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  cfb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd_out),
    .cmd_empty      (cmd_empty),
    .cmd_pop        (cmd_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_frame_byte (out_frame_byte),
    .out_frame_end  (out_frame_end)
  );

endmodule

`default_nettype wire

/* hw/rtl/cfb_cmd_fifo.sv */
// Short command queue between the front classifier and the back serializer.
// Depends on cfb_pkg.
`default_nettype none

module cfb_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire cfb_pkg::cmd_t din,
  output logic               full,
  input  wire logic          pop,
  output cfb_pkg::cmd_t      dout,
  output logic               empty
);
  import cfb_pkg::*;
  `include "assert_macros.svh"

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                   : wr_ptr_r + {{(CMD_PTR_W-1){1'b0}}, 1'b1};
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                   : rd_ptr_r + {{(CMD_PTR_W-1){1'b0}}, 1'b1};
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + {{(CMD_CNT_W-1){1'b0}}, 1'b1};
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - {{(CMD_CNT_W-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `CFB_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CMD_CNT_W'(CMD_DEPTH))
  `CFB_ASSERT_NEXT(a_push_full_hold, clk, rst_n, full && push && !pop, full)
  `CFB_ASSERT_IMPL(a_ptr_match, clk, rst_n, empty || full, wr_ptr_r == rd_ptr_r)

endmodule

`default_nettype wire

/* hw/rtl/cfb_front.sv */
// Front part: tracks the open frame, saturates the length and turns items into commands.
// Depends on cfb_pkg.
`default_nettype none

module cfb_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic                       action,
  input  wire logic [cfb_pkg::SEQ_W-1:0]  seq_num,
  input  wire logic [cfb_pkg::LEN_W-1:0]  payload_length,
  input  wire logic                       end_of_data,
  input  wire logic [cfb_pkg::BYTE_W-1:0] payload_byte,
  output logic                            cmd_push,
  output cfb_pkg::cmd_t                   cmd
);
  import cfb_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned CMP_W = 17;

  logic             open_r, open_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic [LEN_W-1:0] len_sat;
  logic             is_start;
  logic             is_last;

  // classify the transaction and build the command
  always_comb begin
    is_start = (action == ACT_START);
    if ({{(CMP_W - LEN_W){1'b0}}, payload_length} > CMP_W'(MAX_PAYLOAD)) begin
      len_sat = LEN_W'(MAX_PAYLOAD);
    end else begin
      len_sat = payload_length;
    end
    is_last  = (left_r == {{(LEN_W-1){1'b0}}, 1'b1});
    cmd_push = accept && (is_start || open_r);
    cmd.kind = is_start ? CMD_START : CMD_DATA;
    cmd.last = is_last;
    cmd.eod  = end_of_data;
    cmd.seq  = seq_num;
    cmd.len  = len_sat;
    cmd.data = payload_byte;
  end

  // frame tracking; data with no open frame is dropped
  always_comb begin
    open_nxt = open_r;
    left_nxt = left_r;
    if (accept) begin
      priority if (is_start) begin
        open_nxt = (len_sat != '0);
        left_nxt = len_sat;
      end else if (open_r) begin
        left_nxt = left_r - {{(LEN_W-1){1'b0}}, 1'b1};
        open_nxt = !is_last;
      end else begin
        // stray data byte: state holds
        open_nxt = open_r;
        left_nxt = left_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      left_r <= '0;
    end else begin
      open_r <= open_nxt;
      left_r <= left_nxt;
    end
  end

  `CFB_ASSERT_IMPL(a_open_has_bytes, clk, rst_n, open_r, left_r != '0)
  `CFB_ASSERT_NEXT(a_close_on_last, clk, rst_n,
                   accept && action == ACT_DATA && open_r && is_last, !open_r)

endmodule

`default_nettype wire

/* hw/rtl/cfb_back.sv */
// Back part: serializes commands into frame bytes, keeps the checksum, holds the output register.
// Depends on cfb_pkg.
`default_nettype none

module cfb_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cfb_pkg::cmd_t          cmd,
  input  wire logic                   cmd_empty,
  output logic                        cmd_pop,
  output logic                        out_empty,
  input  wire logic                   out_pop,
  output logic [cfb_pkg::BYTE_W-1:0]  out_frame_byte,
  output logic                        out_frame_end
);
  import cfb_pkg::*;
  `include "assert_macros.svh"

  bk_state_t         state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SEQ_W-1:0]  seq_r;
  logic [LEN_W-1:0]  len_r;
  logic              latch_hdr;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_end_r;

  logic              adv;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_end;
  logic [BYTE_W-1:0] hdr_byte;

  assign adv            = !out_valid_r || out_pop;
  assign out_empty      = !out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_end  = out_end_r;

  // header byte after the flag: seq then length, big-endian
  always_comb begin
    unique case (step_r)
      4'd1:    hdr_byte = seq_r[31:24];
      4'd2:    hdr_byte = seq_r[23:16];
      4'd3:    hdr_byte = seq_r[15:8];
      4'd4:    hdr_byte = seq_r[7:0];
      4'd7:    hdr_byte = BYTE_W'(len_r >> 8);
      4'd8:    hdr_byte = len_r[7:0];
      default: hdr_byte = '0;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    emit      = 1'b0;
    emit_byte = '0;
    emit_end  = 1'b0;
    cmd_pop   = 1'b0;
    sum_nxt   = sum_r;
    step_nxt  = step_r;
    latch_hdr = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) begin
          emit    = 1'b1;
          cmd_pop = adv;
          if (cmd.kind == CMD_START) begin
            emit_byte = cmd.eod ? FLAG_LAST : FLAG_MORE;
            sum_nxt   = sum_add('0, emit_byte);
            step_nxt  = STEP_FIRST;
            latch_hdr = adv;
          end else begin
            emit_byte = cmd.data;
            sum_nxt   = sum_add(sum_r, emit_byte);
          end
        end
      end
      BK_HDR: begin
        emit      = 1'b1;
        emit_byte = hdr_byte;
        sum_nxt   = sum_add(sum_r, emit_byte);
        step_nxt  = step_r + {{(STEP_W-1){1'b0}}, 1'b1};
      end
      BK_CHK: begin
        emit      = 1'b1;
        emit_byte = sum_r[7:0];
        emit_end  = 1'b1;
        sum_nxt   = '0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (adv && !cmd_empty) begin
          priority if (cmd.kind == CMD_START) begin
            state_nxt = BK_HDR;
          end else if (cmd.last) begin
            state_nxt = BK_CHK;
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      BK_HDR: begin
        if (adv && step_r == STEP_LAST) begin
          state_nxt = (len_r == '0) ? BK_CHK : BK_IDLE;
        end
      end
      BK_CHK: begin
        if (adv) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      step_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= emit;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= emit_byte;
      out_end_r  <= emit_end;
    end
    if (latch_hdr) begin
      seq_r <= cmd.seq;
      len_r <= cmd.len;
    end
  end

  `CFB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_pop,
                   out_valid_r && $stable(out_byte_r) && $stable(out_end_r))
  `CFB_ASSERT_NEXT(a_chk_to_idle, clk, rst_n, state_r == BK_CHK && adv,
                   state_r == BK_IDLE && out_end_r && out_valid_r)
  `CFB_ASSERT_IMPL(a_pop_idle_only, clk, rst_n, cmd_pop,
                   state_r == BK_IDLE && !cmd_empty)

endmodule

`default_nettype wire

/* tb/sv/checksummed_frame_builder_core_tb.sv */
`timescale 1ns / 1ps
// Testbench for checksummed_frame_builder_core: directed and random frame traffic,
// with a scoreboard class that predicts each serialized byte. Depends on cfb_pkg.

module checksummed_frame_builder_core_tb;

  import cfb_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int TAIL_CYCLES  = 20;
  localparam int HOLD_CYCLES  = 200;   // one long receiver hold-off
  localparam int HOLD_AT_BYTE = 60;
  localparam int RANDOM_ITEMS = 330;

  typedef struct packed {
    logic [BYTE_W-1:0] data_b;
    logic              frame_end;
  } frame_out_t;

  // Scoreboard: tracks the frame state and queues the bytes each command should emit
  class frame_scoreboard;
    bit               frame_open;
    bit [LEN_W-1:0]   bytes_left;
    bit [SUM_W-1:0]   running_sum;
    frame_out_t       pending_bytes[$];
    int               errors;

    // 16-bit sum with end-around carry
    function void add_byte(bit [BYTE_W-1:0] b);
      bit [SUM_W:0] t;
      t = {1'b0, running_sum} + b;
      running_sum = t[SUM_W-1:0] + t[SUM_W];
    endfunction

    function void emit(bit [BYTE_W-1:0] b);
      frame_out_t o;
      o.data_b    = b;
      o.frame_end = 1'b0;
      pending_bytes.push_back(o);
      add_byte(b);
    endfunction

    function void emit_checksum();
      frame_out_t o;
      o.data_b    = running_sum[BYTE_W-1:0];
      o.frame_end = 1'b1;
      pending_bytes.push_back(o);
      frame_open  = 1'b0;
      bytes_left  = '0;
      running_sum = '0;
    endfunction

    function void note_command(bit act, bit [SEQ_W-1:0] seq, bit [LEN_W-1:0] len,
                               bit eod, bit [BYTE_W-1:0] pb);
      bit [31:0] len32;
      if (act == ACT_START) begin
        // lengths over the maximum saturate, header carries the saturated value
        len32 = (len > MAX_PAYLOAD) ? MAX_PAYLOAD : len;
        running_sum = '0;
        emit(eod ? FLAG_LAST : FLAG_MORE);
        emit(seq[31:24]);
        emit(seq[23:16]);
        emit(seq[15:8]);
        emit(seq[7:0]);
        emit(len32[31:24]);
        emit(len32[23:16]);
        emit(len32[15:8]);
        emit(len32[7:0]);
        bytes_left = len32[LEN_W-1:0];
        frame_open = 1'b1;
        if (bytes_left == 0) emit_checksum();
      end else if (frame_open) begin
        emit(pb);
        if (bytes_left > 0) bytes_left--;
        if (bytes_left == 0) emit_checksum();
      end
    endfunction

    function void check_byte(bit [BYTE_W-1:0] data_b, bit frame_end);
      frame_out_t exp_o;
      if (pending_bytes.size() == 0) begin
        $error("frame_byte: unexpected result 0x%02h with nothing expected", data_b);
        errors++;
        return;
      end
      exp_o = pending_bytes.pop_front();
      if (exp_o.data_b !== data_b) begin
        $error("frame_byte mismatch: expected 0x%02h, actual 0x%02h", exp_o.data_b, data_b);
        errors++;
      end
      if (exp_o.frame_end !== frame_end) begin
        $error("frame_end mismatch: expected %0b, actual %0b", exp_o.frame_end, frame_end);
        errors++;
      end
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  logic                in_action = ACT_START;
  logic [SEQ_W-1:0]    in_seq_num = '0;
  logic [LEN_W-1:0]    in_payload_length = '0;
  logic                in_end_of_data = 1'b0;
  logic [BYTE_W-1:0]   in_payload_byte = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  logic [BYTE_W-1:0]   out_frame_byte;
  logic                out_frame_end;

  frame_scoreboard sb = new();
  int  stall_cycles = 0;
  int  bytes_popped = 0;
  int  items_sent = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;
  bit  gen_open = 1'b0;

  checksummed_frame_builder_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_action         (in_action),
    .in_seq_num        (in_seq_num),
    .in_payload_length (in_payload_length),
    .in_end_of_data    (in_end_of_data),
    .in_payload_byte   (in_payload_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_frame_byte    (out_frame_byte),
    .out_frame_end     (out_frame_end)
  );

  always #10 clk = ~clk;

  // Monitors and watchdog; values sampled at the edge are the pre-edge ones
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full)
      sb.note_command(in_action, in_seq_num, in_payload_length, in_end_of_data,
                      in_payload_byte);
    if (rst_n && out_pop && !out_empty)
      sb.check_byte(out_frame_byte, out_frame_end);
    if (rst_n && ((in_push && !in_full) || (out_pop && !out_empty)))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // One input transaction; returns once it has been accepted
  task automatic send_item(bit act, bit [SEQ_W-1:0] seq, bit [LEN_W-1:0] len, bit eod,
                           bit [BYTE_W-1:0] pb);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push           <= 1'b1;
    in_action         <= act;
    in_seq_num        <= seq;
    in_payload_length <= len;
    in_end_of_data    <= eod;
    in_payload_byte   <= pb;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Unused fields carry random values
  task automatic send_start(bit [SEQ_W-1:0] seq, bit [LEN_W-1:0] len, bit eod);
    send_item(ACT_START, seq, len, eod, BYTE_W'($urandom_range(0, 255)));
    gen_open = (len != 0);
    items_sent++;
  endtask

  task automatic send_data(bit [BYTE_W-1:0] pb);
    if (gen_open) items_sent++;
    send_item(ACT_DATA, $urandom, LEN_W'($urandom_range(0, 2047)),
              1'($urandom_range(0, 1)), pb);
  endtask

  task automatic send_payload(int count);
    repeat (count) send_data(BYTE_W'($urandom_range(0, 255)));
  endtask

  // Receiver: random pop gaps, bursts without gaps, and one long hold-off
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 3);
      if (bytes_popped == HOLD_AT_BYTE) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      bytes_popped++;
    end
  end

  // Stimulus and end of run
  initial begin
    int len;
    int sent;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: dropped byte, empty frames, extremes, saturation, abandoned frames
    send_data(8'hFF);
    send_start(32'hFFFF_FFFF, 11'd0, 1'b1);
    send_start(32'h0000_0000, 11'd0, 1'b0);
    send_start(32'h8000_0001, 11'd3, 1'b0);
    send_data(8'hFF);
    send_data(8'h00);
    send_data(8'hFF);
    send_start(32'h5A5A_A5A5, 11'd2047, 1'b0);
    send_data(8'h12);
    send_data(8'hEF);
    send_start(32'h0123_4567, 11'd1025, 1'b1);
    send_data(8'h80);
    send_start(32'hFEDC_BA98, 11'd1024, 1'b1);
    send_data(8'h7F);
    send_start(32'h0000_00FF, 11'd1, 1'b0);
    send_data(8'h55);
    send_data(8'hAA);
    // all-ones content forces end-around carries
    send_start(32'hFFFF_FFFF, 11'd6, 1'b0);
    repeat (6) send_data(8'hFF);

    // Random: mostly complete frames, some abandoned ones and stray bytes
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          // long frame cut short by the next start
          len = $urandom_range(0, 2047);
          send_start($urandom, LEN_W'(len), 1'($urandom_range(0, 1)));
          sent = $urandom_range(0, 4);
          if (len > 0 && sent >= len) sent = len - 1;
          send_payload(sent);
        end
        2, 3: begin
          if (!gen_open) send_payload($urandom_range(1, 3));
          else send_start($urandom, '0, 1'($urandom_range(0, 1)));
        end
        default: begin
          len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
          send_start($urandom, LEN_W'(len), 1'($urandom_range(0, 1)));
          send_payload(len);
          gen_open = 1'b0;
        end
      endcase
    end
    in_push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
